[hw/rtl/force_settle_detector_top_macros.svh]
`ifndef FORCE_SETTLE_DETECTOR_TOP_MACROS_SVH
`define FORCE_SETTLE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fsd_pkg.sv]
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DELTA_W   = 15;
  localparam int unsigned TICKS_W   = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t CFG_STAB_EN   = 2'd0;
  localparam cfg_idx_t CFG_FORCE_THR = 2'd1;
  localparam cfg_idx_t CFG_DELTA_PCT = 2'd2;
  localparam cfg_idx_t CFG_TICKS_REQ = 2'd3;

  // 100 percent in Q8
  localparam logic [DELTA_W-1:0] PCT_SCALE_Q8  = 15'd25600;
  localparam logic [DELTA_W-1:0] DELTA_RST     = 15'd256;
  localparam logic [TICKS_W-1:0] TICKS_REQ_RST = 16'd10;
  localparam logic [TICKS_W-1:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic               stab_en;
    logic [DELTA_W-1:0] delta_pct_q8;
    logic [TICKS_W-1:0] ticks_req;
  } cfg_t;

endpackage

[hw/rtl/fsd_in_if.sv]
`timescale 1ns / 1ps

interface fsd_in_if #(
  parameter int unsigned FORCE_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [FORCE_WIDTH-1:0] force_sample;
  logic                          motor_running;

  modport source (output valid, output force_sample, output motor_running, input ready);
  modport sink   (input valid, input force_sample, input motor_running, output ready);
endinterface

[hw/rtl/fsd_out_if.sv]
`timescale 1ns / 1ps

interface fsd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         moving_done;
  logic [fsd_pkg::TICKS_W-1:0]  stable_ticks;
  logic                         settling_armed;

  modport source (output valid, output moving_done, output stable_ticks,
                  output settling_armed, input ready);
  modport sink   (input valid, input moving_done, input stable_ticks,
                  input settling_armed, output ready);
endinterface

[hw/rtl/fsd_cfg_regs.sv]
`timescale 1ns / 1ps

module fsd_cfg_regs #(
  parameter int unsigned FORCE_WIDTH = 24,
  localparam int unsigned CfgDataW =
    (FORCE_WIDTH > fsd_pkg::TICKS_W) ? FORCE_WIDTH : fsd_pkg::TICKS_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  fsd_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [CfgDataW-1:0]           cfg_wdata_i,
  output fsd_pkg::cfg_t                 cfg_o,
  output logic signed [FORCE_WIDTH-1:0] force_thr_o
);
  import fsd_pkg::*;

  cfg_t                          cfg_d, cfg_q;
  logic signed [FORCE_WIDTH-1:0] thr_d, thr_q;

  always_comb begin
    cfg_d = cfg_q;
    thr_d = thr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STAB_EN:   cfg_d.stab_en      = cfg_wdata_i[0];
        CFG_FORCE_THR: thr_d              = $signed(cfg_wdata_i[FORCE_WIDTH-1:0]);
        CFG_DELTA_PCT: cfg_d.delta_pct_q8 = cfg_wdata_i[DELTA_W-1:0];
        CFG_TICKS_REQ: cfg_d.ticks_req    = cfg_wdata_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stab_en      <= 1'b0;
      cfg_q.delta_pct_q8 <= DELTA_RST;
      cfg_q.ticks_req    <= TICKS_REQ_RST;
      thr_q              <= '0;
    end else begin
      cfg_q <= cfg_d;
      thr_q <= thr_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign force_thr_o = thr_q;

endmodule

[hw/rtl/fsd_stab_check.sv]
`timescale 1ns / 1ps

module fsd_stab_check #(
  parameter int unsigned FORCE_WIDTH = 24
) (
  input  logic signed [FORCE_WIDTH-1:0]  force_i,
  input  logic signed [FORCE_WIDTH-1:0]  prev_i,
  input  logic [fsd_pkg::DELTA_W-1:0]    delta_i,
  output logic                           stable_o
);
  import fsd_pkg::*;

  localparam int unsigned ProdW = FORCE_WIDTH + 16;

  logic signed [FORCE_WIDTH:0] diff;
  logic [FORCE_WIDTH:0]        diff_mag;
  logic [FORCE_WIDTH-1:0]      prev_mag;
  logic [ProdW-1:0]            lhs;
  logic [ProdW-1:0]            rhs;

  // Cross-multiplied relative change: |f - p| * 100% <= delta * |p|
  always_comb begin
    diff     = $signed({force_i[FORCE_WIDTH-1], force_i})
             - $signed({prev_i[FORCE_WIDTH-1], prev_i});
    diff_mag = diff[FORCE_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
    prev_mag = prev_i[FORCE_WIDTH-1] ? $unsigned(-prev_i) : $unsigned(prev_i);
    lhs      = ProdW'(diff_mag) * ProdW'(PCT_SCALE_Q8);
    rhs      = ProdW'(delta_i) * ProdW'(prev_mag);
    stable_o = (prev_i == '0) || (lhs <= rhs);
  end

endmodule

[hw/rtl/fsd_core.sv]
`timescale 1ns / 1ps

module fsd_core #(
  parameter int unsigned FORCE_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsd_pkg::cfg_t                 cfg_i,
  input  logic signed [FORCE_WIDTH-1:0] force_thr_i,
  fsd_in_if.sink                        in_if,
  fsd_out_if.source                     out_if
);
  import fsd_pkg::*;

  // Input register
  logic                          in_vld_d, in_vld_q;
  logic signed [FORCE_WIDTH-1:0] in_force_q;
  logic                          in_run_q;

  // Tracking state
  logic                          armed_d, armed_q;
  logic signed [FORCE_WIDTH-1:0] prev_d, prev_q;
  logic [TICKS_W-1:0]            count_d, count_q;

  // Result register
  logic                          out_vld_d, out_vld_q;
  logic                          out_done_q;
  logic [TICKS_W-1:0]            out_ticks_q;
  logic                          out_armed_q;

  logic advance, in_fire, step;
  logic below, armed_run, stable, reached, done;

  assign advance   = !out_vld_q || out_if.ready;
  assign in_if.ready = !in_vld_q || advance;
  assign in_fire   = in_if.valid && in_if.ready;
  assign step      = in_vld_q && advance;

  fsd_stab_check #(
    .FORCE_WIDTH(FORCE_WIDTH)
  ) u_stab_check (
    .force_i  (in_force_q),
    .prev_i   (prev_q),
    .delta_i  (cfg_i.delta_pct_q8),
    .stable_o (stable)
  );

  always_comb begin
    below     = in_force_q < force_thr_i;
    armed_run = (cfg_i.stab_en && in_run_q) ? !below : armed_q;
    armed_d   = armed_run;
    prev_d    = prev_q;
    count_d   = count_q;
    if (!in_run_q && armed_run) begin
      if (!stable) begin
        count_d = '0;
      end else if (count_q != TICKS_MAX) begin
        count_d = count_q + 1'b1;
      end
      prev_d = in_force_q;
      // disarm once settled
      if (count_d >= cfg_i.ticks_req) begin
        armed_d = 1'b0;
      end
    end
    reached = count_d >= cfg_i.ticks_req;
    done    = !in_run_q && (!cfg_i.stab_en || reached || below);
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      armed_q   <= 1'b0;
      prev_q    <= '0;
      count_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step) begin
        armed_q <= armed_d;
        prev_q  <= prev_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_force_q <= in_if.force_sample;
      in_run_q   <= in_if.motor_running;
    end
    if (step) begin
      out_done_q  <= done;
      out_ticks_q <= count_d;
      out_armed_q <= armed_d;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.moving_done    = out_done_q;
  assign out_if.stable_ticks   = out_ticks_q;
  assign out_if.settling_armed = out_armed_q;

endmodule

[hw/rtl/force_settle_detector_top.sv]
// A result passes through the input register and then the result register before it is valid.
// Throughput: one item per cycle while the result side is not stalled; the tracking state
// feeds back through the combinational subtract, multiply and compare stage.
// Reset: rst_ni clears the tracking state, empties both registers and loads the
// configuration defaults (checking off, threshold 0, 1.00 percent, 10 ticks).
`timescale 1ns / 1ps

module force_settle_detector_top #(
  parameter int unsigned FORCE_WIDTH = 24,
  localparam int unsigned CfgDataW =
    (FORCE_WIDTH > fsd_pkg::TICKS_W) ? FORCE_WIDTH : fsd_pkg::TICKS_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fsd_in_if.sink              in_if,
  fsd_out_if.source           out_if,
  input  logic                cfg_we_i,
  input  fsd_pkg::cfg_idx_t   cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);
  import fsd_pkg::*;

  cfg_t                          cfg;
  logic signed [FORCE_WIDTH-1:0] force_thr;

  fsd_cfg_regs #(
    .FORCE_WIDTH(FORCE_WIDTH)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .force_thr_o (force_thr)
  );

  fsd_core #(
    .FORCE_WIDTH(FORCE_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .force_thr_i (force_thr),
    .in_if       (in_if),
    .out_if      (out_if)
  );

endmodule

[hw/rtl/fsd_checker.sv]
`timescale 1ns / 1ps
`include "force_settle_detector_top_macros.svh"

module fsd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        done_i,
  input logic [fsd_pkg::TICKS_W-1:0] ticks_i,
  input logic                        armed_i
);
  import fsd_pkg::*;

  logic               in_fire, out_fire;
  logic [1:0]         pending_d, pending_q;
  logic [TICKS_W-1:0] last_ticks_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      last_ticks_q <= '0;
    end else begin
      pending_q <= pending_d;
      if (out_fire) begin
        last_ticks_q <= ticks_i;
      end
    end
  end

  `FSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(done_i) && $stable(ticks_i) && $stable(armed_i), "stalled result changed")
  `FSD_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled with empty output")
  `FSD_ASSERT_NOW(a_no_phantom, clk_i, rst_ni, out_valid_i, pending_q != 2'd0, "result without input")
  `FSD_ASSERT_NOW(a_pending_bound, clk_i, rst_ni, 1'b1, pending_q != 2'd3, "more than two items in flight")
  `FSD_ASSERT_NOW(a_ticks_step, clk_i, rst_ni, out_fire, ticks_i == '0 || ticks_i == last_ticks_q || ticks_i == last_ticks_q + 16'd1, "stable tick count jumped")

endmodule

bind force_settle_detector_top fsd_checker u_fsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .done_i      (out_if.moving_done),
  .ticks_i     (out_if.stable_ticks),
  .armed_i     (out_if.settling_armed)
);

[verif/force_settle_checker.sv]
`timescale 1ns / 1ps

module force_settle_checker #(
  parameter int unsigned FORCE_WIDTH = 24,
  parameter int unsigned CFG_W       = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [FORCE_WIDTH-1:0] in_force_i,
  input  logic                          in_running_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          out_done_i,
  input  logic [fsd_pkg::TICKS_W-1:0]   out_ticks_i,
  input  logic                          out_armed_i,
  input  logic                          cfg_we_i,
  input  fsd_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  output int unsigned                   mismatch_cnt_o,
  output int unsigned                   reports_pending_o
);
  import fsd_pkg::*;

  typedef struct packed {
    logic               done;
    logic [TICKS_W-1:0] ticks;
    logic               armed;
  } settle_report_t;

  settle_report_t reports_q[$];

  // shadow of the configuration registers
  logic                          check_en;
  logic signed [FORCE_WIDTH-1:0] arm_level;
  logic [DELTA_W-1:0]            delta_q8;
  logic [TICKS_W-1:0]            ticks_needed;

  // settling tracker state
  logic                          armed;
  logic signed [FORCE_WIDTH-1:0] last_force;
  logic [TICKS_W-1:0]            stable_run;

  int unsigned mismatches;

  function automatic void note_failure(input string msg);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endfunction

  task automatic track_settling(input logic signed [FORCE_WIDTH-1:0] level,
                                input logic running, output settle_report_t rpt);
    logic   below;
    logic   stable;
    logic   reached;
    longint step;
    longint ref_mag;
    below = level < arm_level;
    if (check_en && running) armed = !below;
    if (!running && armed) begin
      if (last_force == '0) begin
        stable = 1'b1;
      end else begin
        step    = longint'(level) - longint'(last_force);
        ref_mag = longint'(last_force);
        if (step < 0) step = -step;
        if (ref_mag < 0) ref_mag = -ref_mag;
        // cross-multiplied percent test, exact in 64 bits
        stable = step * longint'(PCT_SCALE_Q8) <= longint'(delta_q8) * ref_mag;
      end
      if (!stable) stable_run = '0;
      else if (stable_run != TICKS_MAX) stable_run = stable_run + 1'b1;
      last_force = level;
      if (stable_run >= ticks_needed) armed = 1'b0;
    end
    reached    = stable_run >= ticks_needed;
    rpt.done   = !running && (!check_en || reached || below);
    rpt.ticks  = stable_run;
    rpt.armed  = armed;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    settle_report_t want;
    settle_report_t got;
    if (!rst_ni) begin
      reports_q.delete();
      check_en     = 1'b0;
      arm_level    = '0;
      delta_q8     = DELTA_RST;
      ticks_needed = TICKS_REQ_RST;
      armed        = 1'b0;
      last_force   = '0;
      stable_run   = '0;
      mismatches   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STAB_EN:   check_en     = cfg_wdata_i[0];
          CFG_FORCE_THR: arm_level    = cfg_wdata_i[FORCE_WIDTH-1:0];
          CFG_DELTA_PCT: delta_q8     = cfg_wdata_i[DELTA_W-1:0];
          CFG_TICKS_REQ: ticks_needed = cfg_wdata_i[TICKS_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a result always belongs to an older transfer
      if (out_valid_i && out_ready_i) begin
        got = '{out_done_i, out_ticks_i, out_armed_i};
        if (reports_q.size() == 0) begin
          note_failure($sformatf("result with no tick pending: done=%0b ticks=%0d armed=%0b",
                                 got.done, got.ticks, got.armed));
        end else begin
          want = reports_q.pop_front();
          if (got.done !== want.done)
            note_failure($sformatf("moving_done expected %0b, got %0b", want.done, got.done));
          if (got.ticks !== want.ticks)
            note_failure($sformatf("stable_ticks expected %0d, got %0d", want.ticks, got.ticks));
          if (got.armed !== want.armed)
            note_failure($sformatf("settling_armed expected %0b, got %0b",
                                   want.armed, got.armed));
        end
      end
      if (in_valid_i && in_ready_i) begin
        track_settling(in_force_i, in_running_i, want);
        reports_q.push_back(want);
      end
    end
    mismatch_cnt_o    = mismatches;
    reports_pending_o = reports_q.size();
  end

endmodule

[verif/tb_force_settle_detector_top.sv]
`timescale 1ns / 1ps

module tb_force_settle_detector_top;
  import fsd_pkg::*;

  localparam int unsigned FORCE_W         = 24;
  localparam int unsigned CFG_W           = (FORCE_W > TICKS_W) ? FORCE_W : TICKS_W;
  localparam longint      FORCE_MIN       = -(longint'(1) << (FORCE_W - 1));
  localparam longint      FORCE_MAX       = (longint'(1) << (FORCE_W - 1)) - 1;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned TICKS_PER_PHASE = 100;
  localparam longint      TIMEOUT_NS      = 20_000_000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;
  bit                no_idle;
  int unsigned       send_calm;
  int unsigned       ticks_sent;
  longint            cur_thr;
  longint            cur_delta;
  int unsigned       mismatch_cnt;
  int unsigned       reports_pending;

  fsd_in_if #(.FORCE_WIDTH(FORCE_W)) force_ch ();
  fsd_out_if report_ch ();

  force_settle_detector_top #(.FORCE_WIDTH(FORCE_W)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (force_ch),
    .out_if     (report_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  force_settle_checker #(.FORCE_WIDTH(FORCE_W), .CFG_W(CFG_W)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (force_ch.valid),
    .in_ready_i       (force_ch.ready),
    .in_force_i       (force_ch.force_sample),
    .in_running_i     (force_ch.motor_running),
    .out_valid_i      (report_ch.valid),
    .out_ready_i      (report_ch.ready),
    .out_done_i       (report_ch.moving_done),
    .out_ticks_i      (report_ch.stable_ticks),
    .out_armed_i      (report_ch.settling_armed),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_cnt_o   (mismatch_cnt),
    .reports_pending_o(reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint clamp_force(input longint v);
    if (v > FORCE_MAX) return FORCE_MAX;
    if (v < FORCE_MIN) return FORCE_MIN;
    return v;
  endfunction

  function automatic longint any_force();
    return longint'($urandom_range(0, (1 << FORCE_W) - 1)) + FORCE_MIN;
  endfunction

  // fill the bits above a register's width with noise
  function automatic logic [CFG_W-1:0] junk_above(input logic [CFG_W-1:0] v,
                                                  input int unsigned w);
    logic [CFG_W-1:0] keep;
    keep = (CFG_W'(1) << w) - 1'b1;
    return (CFG_W'($urandom) & ~keep) | (v & keep);
  endfunction

  // result side: random stalls with calm stretches
  initial begin
    int unsigned stall;
    int unsigned calm;
    report_ch.ready = 1'b0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (no_idle || calm > 0) begin
        report_ch.ready <= 1'b1;
        if (calm > 0) calm--;
      end else if ($urandom_range(0, 199) == 0) begin
        calm = $urandom_range(40, 150);
        report_ch.ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          report_ch.ready <= 1'b1;
        end else begin
          report_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
          report_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_tick(input longint level, input logic running);
    int unsigned gap;
    gap = (no_idle || send_calm > 0) ? 0 : idle_len();
    if (send_calm > 0) send_calm--;
    else if (!no_idle && $urandom_range(0, 149) == 0) send_calm = $urandom_range(30, 100);
    @(negedge clk);
    if (gap > 0) begin
      force_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    force_ch.valid         <= 1'b1;
    force_ch.force_sample  <= level[FORCE_W-1:0];
    force_ch.motor_running <= running;
    do @(posedge clk); while (!force_ch.ready);
    ticks_sent++;
  endtask

  // hold the sender off until every result is back
  task automatic drain();
    @(negedge clk);
    force_ch.valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic en, input longint thr, input longint delta,
                            input longint need);
    cur_thr   = thr;
    cur_delta = delta;
    write_reg(CFG_STAB_EN, junk_above(CFG_W'(en), 1));
    write_reg(CFG_FORCE_THR, CFG_W'(thr));
    write_reg(CFG_DELTA_PCT, junk_above(CFG_W'(delta), DELTA_W));
    write_reg(CFG_TICKS_REQ, junk_above(CFG_W'(need), TICKS_W));
  endtask

  // arm while running, then stop and wobble around the level the burst ran at
  task automatic send_settle_burst();
    longint      base;
    longint      tol;
    longint      offs;
    int unsigned roll;
    int unsigned n_run;
    int unsigned n_stop;
    case ($urandom_range(0, 9))
      0:       base = any_force();
      1:       base = 0;
      default: base = clamp_force(cur_thr + longint'($urandom_range(0, 3000)));
    endcase
    tol = ((base < 0) ? -base : base) * cur_delta / longint'(PCT_SCALE_Q8);
    n_run  = $urandom_range(1, 4);
    n_stop = $urandom_range(1, 14);
    repeat (n_run) begin
      if ($urandom_range(0, 7) == 0)
        send_tick(clamp_force(cur_thr - 1 - longint'($urandom_range(0, 50))), 1'b1);
      else
        send_tick(clamp_force(base + longint'($urandom_range(0, 50))), 1'b1);
    end
    repeat (n_stop) begin
      roll = $urandom_range(0, 19);
      if (roll < 15) offs = longint'($urandom_range(0, 32'(2 * tol))) - tol;
      else if (roll < 17) offs = $urandom_range(0, 1) ? tol : -tol;
      else offs = (tol + 1 + longint'($urandom_range(0, 300))) * ($urandom_range(0, 1) ? 1 : -1);
      send_tick(clamp_force(base + offs), 1'b0);
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned start;
    logic        en;
    longint      thr;
    longint      delta;
    longint      need;
    rst_n                  = 1'b0;
    force_ch.valid         = 1'b0;
    force_ch.force_sample  = '0;
    force_ch.motor_running = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_STAB_EN;
    cfg_wdata              = '0;
    no_idle                = 1'b0;
    send_calm              = 0;
    ticks_sent             = 0;
    cur_thr                = 0;
    cur_delta              = DELTA_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: checking off, done follows the motor alone
    send_tick(FORCE_MAX, 1'b1);
    send_tick(FORCE_MIN, 1'b0);
    send_tick(0, 1'b0);
    send_tick(-1, 1'b1);

    drain();
    set_config(1'b1, 1000, 256, 3);
    send_tick(2000, 1'b1);
    send_tick(999, 1'b1);   // below threshold: disarm
    send_tick(1000, 1'b1);  // at threshold: arm
    send_tick(2000, 1'b0);  // previous sample zero counts as stable
    send_tick(2020, 1'b0);  // change exactly at the limit
    send_tick(2100, 1'b0);  // too large: count clears
    send_tick(2100, 1'b0);
    send_tick(2100, 1'b0);
    send_tick(2100, 1'b0);  // requirement met: disarm
    send_tick(500, 1'b0);
    send_tick(500, 1'b1);

    drain();
    set_config(1'b1, FORCE_MIN, 0, 0);
    send_tick(FORCE_MIN, 1'b1);
    send_tick(FORCE_MIN, 1'b0);
    send_tick(-5, 1'b1);
    send_tick(-5, 1'b0);
    send_tick(-5, 1'b1);
    send_tick(-5, 1'b0);

    drain();
    set_config(1'b0, FORCE_MAX, 15'h7FFF, TICKS_MAX);
    send_tick(FORCE_MAX, 1'b0);
    send_tick(FORCE_MAX, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = (p < 4) ? p : $urandom_range(0, 7);
      en   = (p == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
      case (pick)
        0:       thr = FORCE_MIN;
        1:       thr = FORCE_MAX;
        2:       thr = 0;
        default: thr = longint'($urandom_range(0, 10000)) - 5000;
      endcase
      case ((pick + 1) % 8)
        0:       delta = 0;
        1:       delta = 15'h7FFF;
        2:       delta = PCT_SCALE_Q8;
        default: delta = $urandom_range(0, 2000);
      endcase
      case ((pick + 2) % 8)
        0:       need = 0;
        1:       need = 1;
        2:       need = TICKS_MAX;
        default: need = $urandom_range(2, 8);
      endcase
      drain();
      set_config(en, thr, delta, need);
      start = ticks_sent;
      while (ticks_sent - start < TICKS_PER_PHASE) begin
        if ($urandom_range(0, 4) != 0) send_settle_burst();
        else send_tick(any_force(), 1'(($urandom_range(0, 1))));
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fsd_pkg.sv
hw/rtl/fsd_in_if.sv
hw/rtl/fsd_out_if.sv
hw/rtl/fsd_cfg_regs.sv
hw/rtl/fsd_stab_check.sv
hw/rtl/fsd_core.sv
hw/rtl/force_settle_detector_top.sv
hw/rtl/fsd_checker.sv
verif/force_settle_checker.sv
verif/tb_force_settle_detector_top.sv
